// ----- hw/rtl/json_string_escaper_utf8_top_defines.svh -----
// assertion helpers used by the checker file
// both expect clk and rst_n to be visible where they are used
`ifndef JSON_STRING_ESCAPER_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_ESCAPER_UTF8_TOP_DEFINES_SVH

// condition holds in the cycle after the trigger
`define JSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jse: expected follow-up condition missing");

// signal unchanged in the cycle after the trigger
`define JSE_ASSERT_HOLD(lbl, ante, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
        else $error("jse: signal changed while it had to hold");

`endif

// ----- hw/rtl/jse_pkg.sv -----
`default_nettype none

package jse_pkg;

    // how one decoded character turns into output bytes
    typedef enum logic [1:0] {
        FORM_RAW,
        FORM_ESC2,
        FORM_UESC
    } form_t;

    // raw: bytes low first; esc2: letter in the low byte;
    // uesc: first word in the upper half, second word (pair only) in the lower half
    typedef struct packed {
        form_t       form;
        logic [3:0]  len;
        logic [31:0] data;
    } unit_t;

    typedef struct packed {
        logic [2:0]       n_units;
        unit_t [3:0]      units;
        logic             pend_wr;
        logic [1:0]       pend_idx;
        logic [1:0]       pend_cnt;
        logic [2:0]       exp_len;
    } dec_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

    localparam logic [20:0] PRINT_LO   = 21'h20;
    localparam logic [20:0] PRINT_HI   = 21'h7E;
    localparam logic [20:0] MIN_CP2    = 21'h80;
    localparam logic [20:0] MIN_CP3    = 21'h800;
    localparam logic [20:0] SURR_FIRST = 21'hD800;
    localparam logic [20:0] SURR_LAST  = 21'hDFFF;
    localparam logic [20:0] BMP_LAST   = 21'hFFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [20:0] MAX_CP     = 21'h10FFFF;

    localparam logic [15:0] REPL_CHAR = 16'hFFFD;
    localparam logic [15:0] SURR_HI   = 16'hD800;
    localparam logic [15:0] SURR_LO   = 16'hDC00;

    localparam logic [3:0] LEN_ESC2  = 4'd2;
    localparam logic [3:0] LEN_UESC  = 4'd6;
    localparam logic [3:0] LEN_PAIR  = 4'd12;

endpackage

`default_nettype wire

// ----- hw/rtl/jse_decode.sv -----
`default_nettype none

module jse_decode (
    input  wire logic [2:0][7:0] pend,
    input  wire logic [1:0]      pend_cnt,
    input  wire logic [2:0]      exp_len,
    input  wire logic [7:0]      in_byte,
    input  wire logic            eos,
    input  wire logic            esc,
    output jse_pkg::dec_t        dec
);

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] r;
        if (!b[7])
            r = 3'd1;
        else if (b[7:5] == 3'b110)
            r = 3'd2;
        else if (b[7:4] == 4'b1110)
            r = 3'd3;
        else if (b[7:3] == 5'b11110)
            r = 3'd4;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic jse_pkg::unit_t make_fffd(input logic [7:0] b, input logic e);
        jse_pkg::unit_t u;
        if (e)
        begin
            u.form = jse_pkg::FORM_UESC;
            u.len  = jse_pkg::LEN_UESC;
            u.data = {jse_pkg::REPL_CHAR, 16'h0000};
        end
        else
        begin
            u.form = jse_pkg::FORM_RAW;
            u.len  = 4'd1;
            u.data = {24'h000000, b};
        end
        return u;
    endfunction

    function automatic jse_pkg::unit_t make_code(input logic [20:0] cp,
                                                 input logic [31:0] raw,
                                                 input logic [2:0]  nraw,
                                                 input logic        e);
        jse_pkg::unit_t u;
        logic [7:0]     letter;
        logic [20:0]    off;
        letter = 8'h00;
        off    = cp - jse_pkg::SUPP_BASE;
        if (cp[20:8] == 13'd0)
        begin
            unique case (cp[7:0])
                jse_pkg::CH_QUOTE:  letter = jse_pkg::CH_QUOTE;
                jse_pkg::CH_BSLASH: letter = jse_pkg::CH_BSLASH;
                jse_pkg::CH_SLASH:  letter = jse_pkg::CH_SLASH;
                jse_pkg::CH_BS:     letter = jse_pkg::CH_LOW_B;
                jse_pkg::CH_FF:     letter = jse_pkg::CH_LOW_F;
                jse_pkg::CH_LF:     letter = jse_pkg::CH_LOW_N;
                jse_pkg::CH_CR:     letter = jse_pkg::CH_LOW_R;
                jse_pkg::CH_TAB:    letter = jse_pkg::CH_LOW_T;
                default:            letter = 8'h00;
            endcase
        end
        if (letter != 8'h00)
        begin
            u.form = jse_pkg::FORM_ESC2;
            u.len  = jse_pkg::LEN_ESC2;
            u.data = {24'h000000, letter};
        end
        else if ((cp >= jse_pkg::PRINT_LO && cp <= jse_pkg::PRINT_HI) || !e)
        begin
            u.form = jse_pkg::FORM_RAW;
            u.len  = {1'b0, nraw};
            u.data = raw;
        end
        else if (cp <= jse_pkg::BMP_LAST)
        begin
            u.form = jse_pkg::FORM_UESC;
            u.len  = jse_pkg::LEN_UESC;
            u.data = {cp[15:0], 16'h0000};
        end
        else
        begin
            // supplementary plane: surrogate pair
            u.form = jse_pkg::FORM_UESC;
            u.len  = jse_pkg::LEN_PAIR;
            u.data = {jse_pkg::SURR_HI | {6'd0, off[19:10]},
                      jse_pkg::SURR_LO | {6'd0, off[9:0]}};
        end
        return u;
    endfunction

    logic [3:0][7:0]  seq_b;
    logic             is_cont;
    logic [2:0]       fresh_len;
    logic             fresh_code;
    logic             fresh_bad;
    logic             fresh_hold;
    logic [2:0]       cnt_plus1;
    logic             complete;
    logic [20:0]      cp;
    logic             cp_bad;
    logic [20:0]      code_cp;
    logic [31:0]      code_raw;
    logic [2:0]       code_nraw;
    logic [2:0]       n_fffd;
    logic             has_code;
    logic             hold_fresh;
    logic             hold_append;
    jse_pkg::unit_t   code_unit;

    // the new byte sits right after the held ones
    assign seq_b[0] = (pend_cnt == 2'd0) ? in_byte : pend[0];
    assign seq_b[1] = (pend_cnt == 2'd1) ? in_byte : pend[1];
    assign seq_b[2] = (pend_cnt == 2'd2) ? in_byte : pend[2];
    assign seq_b[3] = in_byte;

    assign is_cont    = (in_byte[7:6] == 2'b10);
    assign fresh_len  = lead_len(in_byte);
    assign fresh_code = (fresh_len == 3'd1);
    assign fresh_bad  = (fresh_len == 3'd0) || ((fresh_len > 3'd1) && eos);
    assign fresh_hold = (fresh_len > 3'd1) && !eos;
    assign cnt_plus1  = {1'b0, pend_cnt} + 3'd1;
    assign complete   = (pend_cnt != 2'd0) && is_cont && (cnt_plus1 == exp_len);

    always_comb
    begin
        unique case (exp_len)
            3'd2:
            begin
                cp     = {10'd0, seq_b[0][4:0], seq_b[1][5:0]};
                cp_bad = cp < jse_pkg::MIN_CP2;
            end
            3'd3:
            begin
                cp     = {5'd0, seq_b[0][3:0], seq_b[1][5:0], seq_b[2][5:0]};
                cp_bad = (cp < jse_pkg::MIN_CP3)
                      || (cp >= jse_pkg::SURR_FIRST && cp <= jse_pkg::SURR_LAST);
            end
            3'd4:
            begin
                cp     = {seq_b[0][2:0], seq_b[1][5:0], seq_b[2][5:0], seq_b[3][5:0]};
                cp_bad = (cp < jse_pkg::SUPP_BASE) || (cp > jse_pkg::MAX_CP);
            end
            default:
            begin
                cp     = 21'd0;
                cp_bad = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (complete)
        begin
            code_cp   = cp;
            code_raw  = seq_b;
            code_nraw = exp_len;
        end
        else
        begin
            code_cp   = {13'd0, in_byte};
            code_raw  = {24'h000000, in_byte};
            code_nraw = 3'd1;
        end
    end

    assign code_unit = make_code(code_cp, code_raw, code_nraw, esc);

    always_comb
    begin
        n_fffd      = 3'd0;
        has_code    = 1'b0;
        hold_fresh  = 1'b0;
        hold_append = 1'b0;
        priority if (pend_cnt == 2'd0)
        begin
            n_fffd     = {2'd0, fresh_bad};
            has_code   = fresh_code;
            hold_fresh = fresh_hold;
        end
        else if (complete)
        begin
            // a rejected sequence falls apart into one replacement per byte
            if (cp_bad)
                n_fffd = cnt_plus1;
            else
                has_code = 1'b1;
        end
        else if (is_cont)
        begin
            if (eos)
                n_fffd = cnt_plus1;
            else
                hold_append = 1'b1;
        end
        else
        begin
            n_fffd     = {1'b0, pend_cnt} + {2'd0, fresh_bad};
            has_code   = fresh_code;
            hold_fresh = fresh_hold;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            dec.units[i] = (3'(i) < n_fffd) ? make_fffd(seq_b[i], esc) : code_unit;
        dec.n_units = n_fffd + {2'd0, has_code};
        if (hold_append)
        begin
            dec.pend_wr  = 1'b1;
            dec.pend_idx = pend_cnt;
            dec.pend_cnt = cnt_plus1[1:0];
            dec.exp_len  = exp_len;
        end
        else if (hold_fresh)
        begin
            dec.pend_wr  = 1'b1;
            dec.pend_idx = 2'd0;
            dec.pend_cnt = 2'd1;
            dec.exp_len  = fresh_len;
        end
        else
        begin
            dec.pend_wr  = 1'b0;
            dec.pend_idx = 2'd0;
            dec.pend_cnt = 2'd0;
            dec.exp_len  = 3'd0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_escaper_utf8_top.sv -----
// JSON string escaper for a UTF-8 byte stream.
// Input channel (in_valid/in_ready): one string byte per item, end_of_string on
// the final byte. Output channel (out_valid/out_ready): one escaped byte per
// item, last_in_run high on the final byte that one input item produces.
// cfg_wr_en/cfg_wr_data write escape_non_ascii; write it only
// while the block is idle.
// An accepted byte is decoded combinationally into a plan of up to four
// characters, loaded at the accepting edge; the emitter then sends one output
// byte per cycle while the receiver does not stall, each byte passing through
// the output register.
// Throughput: the emitter holds an item until all of its output bytes are sent
// and takes the next item as the last one goes out, so plain ASCII runs at one
// byte per cycle while the receiver keeps up and escapes hold off the input; an
// item that completes nothing (a held lead or continuation byte) gives no output.
// Reset clears the held sequence, the plan and the output valid flag and sets
// escape_non_ascii to 0. When the receiver stalls, the output register holds
// its byte and the input is taken again once the current plan has been sent.
`default_nettype none

module json_string_escaper_utf8_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_string,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_in_run
);

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
            r = jse_pkg::CH_ZERO + {4'd0, nib};
        else
            r = jse_pkg::HEX_ALPHA_BASE + {4'd0, nib};
        return r;
    endfunction

    function automatic logic [7:0] unit_byte(input jse_pkg::unit_t u, input logic [3:0] j);
        logic [3:0]  jj;
        logic [15:0] w;
        logic [3:0]  nib;
        logic [7:0]  r;
        jj = (j >= 4'd6) ? j - 4'd6 : j;
        w  = (j >= 4'd6) ? u.data[15:0] : u.data[31:16];
        unique case (jj)
            4'd2:    nib = w[15:12];
            4'd3:    nib = w[11:8];
            4'd4:    nib = w[7:4];
            default: nib = w[3:0];
        endcase
        unique case (u.form)
            jse_pkg::FORM_RAW:
                r = u.data[8 * j[1:0] +: 8];
            jse_pkg::FORM_ESC2:
                r = (j == 4'd0) ? jse_pkg::CH_BSLASH : u.data[7:0];
            jse_pkg::FORM_UESC:
            begin
                if (jj == 4'd0)
                    r = jse_pkg::CH_BSLASH;
                else if (jj == 4'd1)
                    r = jse_pkg::CH_LOW_U;
                else
                    r = hex_char(nib);
            end
            default:
                r = u.data[7:0];
        endcase
        return r;
    endfunction

    logic                 esc_reg;
    logic [2:0][7:0]      pend_reg;
    logic [1:0]           pend_cnt_reg;
    logic [2:0]           exp_len_reg;

    logic                 plan_vld_reg;
    logic                 plan_vld_next;
    logic [2:0]           left_reg;
    logic [2:0]           left_next;
    logic [3:0]           idx_reg;
    logic [3:0]           idx_next;
    jse_pkg::unit_t [3:0] units_reg;
    jse_pkg::unit_t [3:0] units_next;

    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic [7:0]           out_byte_reg;
    logic [7:0]           out_byte_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    jse_pkg::dec_t        dec;
    jse_pkg::unit_t       cur;
    logic                 accept;
    logic                 out_free;
    logic                 step;
    logic                 unit_end;
    logic                 last_unit;
    logic                 plan_done;

    jse_decode u_decode (
        .pend     (pend_reg),
        .pend_cnt (pend_cnt_reg),
        .exp_len  (exp_len_reg),
        .in_byte  (in_byte),
        .eos      (end_of_string),
        .esc      (esc_reg),
        .dec      (dec)
    );

    assign cur       = units_reg[0];
    assign out_free  = !out_vld_reg || out_ready;
    assign step      = plan_vld_reg && out_free;
    assign unit_end  = (idx_reg == cur.len - 4'd1);
    assign last_unit = (left_reg == 3'd1);
    assign plan_done = step && unit_end && last_unit;
    assign in_ready  = !plan_vld_reg || plan_done;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        plan_vld_next = plan_vld_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        units_next    = units_reg;
        if (accept && dec.n_units != 3'd0)
        begin
            plan_vld_next = 1'b1;
            left_next     = dec.n_units;
            idx_next      = 4'd0;
            units_next    = dec.units;
        end
        else if (plan_done)
        begin
            plan_vld_next = 1'b0;
        end
        else if (step)
        begin
            if (unit_end)
            begin
                // next character moves to the head of the plan
                units_next[2:0] = units_reg[3:1];
                left_next       = left_reg - 3'd1;
                idx_next        = 4'd0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        if (step)
        begin
            out_vld_next  = 1'b1;
            out_byte_next = unit_byte(cur, idx_reg);
            out_last_next = unit_end && last_unit;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg      <= 1'b0;
            pend_cnt_reg <= 2'd0;
            exp_len_reg  <= 3'd0;
            plan_vld_reg <= 1'b0;
            left_reg     <= 3'd0;
            idx_reg      <= 4'd0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                esc_reg <= cfg_wr_data;
            if (accept)
            begin
                pend_cnt_reg <= dec.pend_cnt;
                exp_len_reg  <= dec.exp_len;
            end
            plan_vld_reg <= plan_vld_next;
            left_reg     <= left_next;
            idx_reg      <= idx_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && dec.pend_wr)
            pend_reg[dec.pend_idx] <= in_byte;
        units_reg    <= units_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_vld_reg;
    assign out_byte    = out_byte_reg;
    assign last_in_run = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/jse_checker.sv -----
`default_nettype none

`include "json_string_escaper_utf8_top_defines.svh"

module jse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_in_run
);

    `JSE_ASSERT_HOLD(a_out_byte_held, out_valid && !out_ready, out_byte)
    `JSE_ASSERT_HOLD(a_out_last_held, out_valid && !out_ready, last_in_run)
    // bytes of one item leave without gaps
    `JSE_ASSERT_NEXT(a_run_unbroken, out_valid && out_ready && !last_in_run, out_valid)
    // input only stalls while there is output on its way
    `JSE_ASSERT_NEXT(a_busy_means_output, !in_ready, out_valid)

endmodule

bind json_string_escaper_utf8_top jse_checker u_jse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_in_run (last_in_run)
);

`default_nettype wire
